### rtl/aacp_pkg.sv
package aacp_pkg;

    // Field and configuration widths
    localparam int COORD_W  = 6;
    localparam int SIZE_W   = 7;
    localparam int THR_W    = 10;
    localparam int DIST_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int COLOR_W  = 8;

    // Largest sprite side in pixels
    localparam int MAX_SIZE = 64;

    // Subsample grid: 4 per axis, 16 per pixel
    localparam int SUBS     = 4;
    localparam int ROW_CNT_W = 3;
    localparam int CNT_W    = 5;

    // Grey shading constants
    localparam int GREY_FULL   = 204;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int QUOT_W      = 8;
    localparam int NUMER_W     = 12;
    localparam int PROD_W      = 16;
    // floor(p/255) == (p * DIV255_MUL) >> DIV255_SHIFT for p < 2^16
    localparam int DIV255_MUL   = 32'h8081;
    localparam int DIV255_SHIFT = 23;

    // ceil(2^16 / n) for n = 1..16; zero coverage maps to zero
    localparam logic [RECIP_W-1:0] RECIP_TBL [0:16] = '{
        17'd0,     17'd65536, 17'd32768, 17'd21846, 17'd16384,
        17'd13108, 17'd10923, 17'd9363,  17'd8192,  17'd7282,
        17'd6554,  17'd5958,  17'd5462,  17'd5042,  17'd4682,
        17'd4370,  17'd4096
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRITE_SIZE  = 3'd0,
        CFG_PREMULTIPLY  = 3'd1,
        CFG_ARM_LENGTH   = 3'd2,
        CFG_OUTLINE_HALF = 3'd3,
        CFG_CORE_HALF    = 3'd4
    } t_cfg_idx;

    // Reset values
    localparam logic [SIZE_W-1:0] RST_SPRITE_SIZE  = 7'd48;
    localparam logic              RST_PREMULTIPLY  = 1'b0;
    localparam logic [THR_W-1:0]  RST_ARM_LENGTH   = 10'd180;
    localparam logic [THR_W-1:0]  RST_OUTLINE_HALF = 10'd18;
    localparam logic [THR_W-1:0]  RST_CORE_HALF    = 10'd10;

    typedef struct packed {
        logic [SIZE_W-1:0] sprite_size;
        logic              premultiply_on;
        logic [THR_W-1:0]  arm_length_eighths;
        logic [THR_W-1:0]  outline_half_eighths;
        logic [THR_W-1:0]  core_half_eighths;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] alpha;
        logic [COLOR_W-1:0] grey;
    } t_out_item;

    // Per-axis subsample distances from the sprite center
    typedef struct packed {
        logic [SUBS-1:0][DIST_W-1:0] dx;
        logic [SUBS-1:0][DIST_W-1:0] dy;
        logic                        outside;
    } t_dist_item;

    // Subsample counts for one pixel
    typedef struct packed {
        logic [CNT_W-1:0] covered;
        logic [CNT_W-1:0] core;
    } t_count_item;

endpackage

### rtl/aacp_dist.sv
module aacp_dist
    import aacp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_dist_item o_item
);

    logic                     r_vld;
    t_dist_item               r_item;
    t_dist_item               n_item;
    logic [SIZE_W-1:0]        w_size;
    logic signed [11:0]       w_centre;

    // Effective size, clamped to the largest sprite
    assign w_size = (i_cfg.sprite_size > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE)
                                                            : i_cfg.sprite_size;
    // Center in eighth pixels: 4*(size-1)
    assign w_centre = $signed({3'b000, w_size, 2'b00}) - 12'sd4;

    // Distance per subsample offset, both axes
    always_comb begin
        logic [9:0]         pos_x;
        logic [9:0]         pos_y;
        logic signed [11:0] diff_x;
        logic signed [11:0] diff_y;
        logic [11:0]        abs_x;
        logic [11:0]        abs_y;
        n_item = '0;
        for (int s = 0; s < SUBS; s++) begin
            pos_x  = {1'b0, i_item.column, 3'b000} + 10'(2 * s + 1);
            pos_y  = {1'b0, i_item.row, 3'b000} + 10'(2 * s + 1);
            diff_x = $signed({2'b00, pos_x}) - w_centre;
            diff_y = $signed({2'b00, pos_y}) - w_centre;
            abs_x  = diff_x[11] ? 12'(-diff_x) : 12'(diff_x);
            abs_y  = diff_y[11] ? 12'(-diff_y) : 12'(diff_y);
            n_item.dx[s] = abs_x[DIST_W-1:0];
            n_item.dy[s] = abs_y[DIST_W-1:0];
        end
        n_item.outside = ({1'b0, i_item.column} >= w_size) ||
                         ({1'b0, i_item.row} >= w_size);
    end

    assign o_ready = !r_vld || i_ready;

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

### rtl/aacp_cover.sv
module aacp_cover
    import aacp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_dist_item  i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_count_item o_item
);

    localparam int NSTG = 3;

    // Threshold flags per axis subsample
    typedef struct packed {
        logic [SUBS-1:0] x_out;
        logic [SUBS-1:0] x_arm;
        logic [SUBS-1:0] x_core;
        logic [SUBS-1:0] y_out;
        logic [SUBS-1:0] y_arm;
        logic [SUBS-1:0] y_core;
        logic            outside;
    } t_flags;

    // Counts per subsample row
    typedef struct packed {
        logic [SUBS-1:0][ROW_CNT_W-1:0] cov;
        logic [SUBS-1:0][ROW_CNT_W-1:0] core;
    } t_rows;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_rdy;
    t_flags          r_flags;
    t_flags          n_flags;
    t_rows           r_rows;
    t_rows           n_rows;
    t_count_item     r_cnt;
    t_count_item     n_cnt;

    // Per-stage ready: a stage moves when empty or its successor moves
    always_comb begin
        w_rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Stage 1: threshold compares
    always_comb begin
        for (int s = 0; s < SUBS; s++) begin
            n_flags.x_out[s]  = i_item.dx[s] <= i_cfg.outline_half_eighths;
            n_flags.x_arm[s]  = i_item.dx[s] <= i_cfg.arm_length_eighths;
            n_flags.x_core[s] = i_item.dx[s] <= i_cfg.core_half_eighths;
            n_flags.y_out[s]  = i_item.dy[s] <= i_cfg.outline_half_eighths;
            n_flags.y_arm[s]  = i_item.dy[s] <= i_cfg.arm_length_eighths;
            n_flags.y_core[s] = i_item.dy[s] <= i_cfg.core_half_eighths;
        end
        n_flags.outside = i_item.outside;
    end

    // Stage 2: arm membership and per-row counts
    always_comb begin
        logic v_arm;
        logic h_arm;
        logic cov;
        logic core;
        n_rows = '0;
        for (int sy = 0; sy < SUBS; sy++) begin
            for (int sx = 0; sx < SUBS; sx++) begin
                v_arm = r_flags.x_out[sx] && r_flags.y_arm[sy];
                h_arm = r_flags.y_out[sy] && r_flags.x_arm[sx];
                cov   = (v_arm || h_arm) && !r_flags.outside;
                core  = cov && ((v_arm && r_flags.x_core[sx]) ||
                                (h_arm && r_flags.y_core[sy]));
                n_rows.cov[sy]  = n_rows.cov[sy] + ROW_CNT_W'(cov);
                n_rows.core[sy] = n_rows.core[sy] + ROW_CNT_W'(core);
            end
        end
    end

    // Stage 3: pixel totals
    always_comb begin
        n_cnt = '0;
        for (int sy = 0; sy < SUBS; sy++) begin
            n_cnt.covered = n_cnt.covered + CNT_W'(r_rows.cov[sy]);
            n_cnt.core    = n_cnt.core + CNT_W'(r_rows.core[sy]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) r_flags <= n_flags;
        if (w_rdy[1]) r_rows  <= n_rows;
        if (w_rdy[2]) r_cnt   <= n_cnt;
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_item  = r_cnt;

`ifndef NO_ASSERTIONS
    a_core_le_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_cnt.core <= r_cnt.covered))
        else $error("core count exceeds covered count");

    a_cov_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_cnt.covered <= CNT_W'(SUBS * SUBS)))
        else $error("covered count above subsample total");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !i_ready) |=> (r_vld[2] && $stable(r_cnt)))
        else $error("stalled count item lost or changed");
`endif

endmodule

### rtl/aacp_shade.sv
module aacp_shade
    import aacp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_count_item i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);

    localparam int NSTG = 4;

    logic [NSTG-1:0]      r_vld;
    logic [NSTG:0]        w_rdy;

    // Stage 1 registers
    logic [COLOR_W-1:0]   r1_alpha;
    logic [NUMER_W-1:0]   r1_numer;
    logic [RECIP_W-1:0]   r1_recip;
    // Stage 2 registers
    logic [COLOR_W-1:0]   r2_alpha;
    logic [QUOT_W-1:0]    r2_quot;
    // Stage 3 registers
    logic [COLOR_W-1:0]   r3_alpha;
    logic [QUOT_W-1:0]    r3_quot;
    logic [PROD_W-1:0]    r3_prod;
    // Stage 4 register
    t_out_item            r4_item;

    logic [12:0]          w_alpha_x255;
    logic [28:0]          w_quot_full;
    logic [31:0]          w_div255;

    always_comb begin
        w_rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // alpha = covered*255/16
    assign w_alpha_x255 = {i_item.covered, 8'b0} - 13'(i_item.covered);
    // core*204/covered by reciprocal multiply
    assign w_quot_full  = 29'(r1_numer) * 29'(r1_recip);
    // grey*alpha/255 by reciprocal multiply
    assign w_div255     = 32'(r3_prod) * 32'(DIV255_MUL);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_alpha <= w_alpha_x255[11:4];
            r1_numer <= NUMER_W'(i_item.core) * NUMER_W'(GREY_FULL);
            r1_recip <= RECIP_TBL[i_item.covered];
        end
        if (w_rdy[1]) begin
            r2_alpha <= r1_alpha;
            r2_quot  <= w_quot_full[RECIP_SHIFT +: QUOT_W];
        end
        if (w_rdy[2]) begin
            r3_alpha <= r2_alpha;
            r3_quot  <= r2_quot;
            r3_prod  <= PROD_W'(r2_quot) * PROD_W'(r2_alpha);
        end
        if (w_rdy[3]) begin
            r4_item.alpha <= r3_alpha;
            r4_item.grey  <= i_cfg.premultiply_on ? w_div255[DIV255_SHIFT +: COLOR_W]
                                                  : r3_quot;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_item  = r4_item;

`ifndef NO_ASSERTIONS
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r4_item.alpha == '0) |-> (r4_item.grey == '0))
        else $error("grey set on a pixel without coverage");

    a_grey_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r4_item.grey <= COLOR_W'(GREY_FULL)))
        else $error("grey above full level");

    a_quot_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r2_quot <= QUOT_W'(GREY_FULL)))
        else $error("reciprocal quotient out of range");
`endif

endmodule

### rtl/antialiased_crosshair_pixel_top.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_in_item  (column, row)
// result    o_out_valid / i_out_ready  o_out_item (alpha, grey)
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result side is ready; from accept to result valid an item passes:
// 1 distance stage, 3 coverage stages (compare, row count, total), 4 shading
// stages (reciprocal lookup, quotient multiply, premultiply product, divide by 255).
// Each stage holds its own valid bit and moves when empty or its successor moves,
// so a stalled result keeps intake open until every stage is full.
// Synchronous active-low reset clears valid bits and restores register defaults.
module antialiased_crosshair_pixel_top
    import aacp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        w_dist_vld;
    logic        w_dist_rdy;
    t_dist_item  w_dist_item;
    logic        w_cnt_vld;
    logic        w_cnt_rdy;
    t_count_item w_cnt_item;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_size          <= RST_SPRITE_SIZE;
            r_cfg.premultiply_on       <= RST_PREMULTIPLY;
            r_cfg.arm_length_eighths   <= RST_ARM_LENGTH;
            r_cfg.outline_half_eighths <= RST_OUTLINE_HALF;
            r_cfg.core_half_eighths    <= RST_CORE_HALF;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SPRITE_SIZE:  r_cfg.sprite_size          <= i_cfg_data[SIZE_W-1:0];
                CFG_PREMULTIPLY:  r_cfg.premultiply_on       <= i_cfg_data[0];
                CFG_ARM_LENGTH:   r_cfg.arm_length_eighths   <= i_cfg_data[THR_W-1:0];
                CFG_OUTLINE_HALF: r_cfg.outline_half_eighths <= i_cfg_data[THR_W-1:0];
                CFG_CORE_HALF:    r_cfg.core_half_eighths    <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    aacp_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_dist_vld),
        .i_ready (w_dist_rdy),
        .o_item  (w_dist_item)
    );

    aacp_cover u_cover (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_dist_vld),
        .o_ready (w_dist_rdy),
        .i_item  (w_dist_item),
        .o_valid (w_cnt_vld),
        .i_ready (w_cnt_rdy),
        .o_item  (w_cnt_item)
    );

    aacp_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_cnt_vld),
        .o_ready (w_cnt_rdy),
        .i_item  (w_cnt_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import aacp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 26;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 190;
    localparam int TAIL_CYCLES = 16;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    antialiased_crosshair_pixel_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow registers and pixel expectations
    t_cfg      shade_cfg;
    t_out_item pending_pixels [$];
    int        fail_count;
    logic      no_idle;

    // Typed expectation travels beside the item, like a sideband payload
    logic      typed_on;
    t_out_item typed_shade;

    // Directed stimulus: register writes and pixels, some with typed results
    typedef struct packed {
        logic                 is_write;
        t_cfg_idx             idx;
        logic [CFG_DAT_W-1:0] data;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic                 typed;
        logic [COLOR_W-1:0]   alpha;
        logic [COLOR_W-1:0]   grey;
    } t_step;

    localparam int N_STEPS = 37;

    t_step directed_steps [N_STEPS] = '{
        // reset setup: center, no coverage, outside
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd23, 6'd23, 1'b1, 8'd255, 8'd204},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd0,  6'd0,  1'b1, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd63, 6'd63, 1'b1, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd47, 6'd23, 1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd24, 6'd23, 1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd23, 6'd45, 1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd0,  6'd63, 1'b1, 8'd0,   8'd0},
        // premultiplied
        '{1'b1, CFG_PREMULTIPLY,  10'd1,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd23, 6'd23, 1'b1, 8'd255, 8'd204},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd25, 6'd21, 1'b0, 8'd0,   8'd0},
        // size above the maximum is clamped
        '{1'b1, CFG_SPRITE_SIZE,  10'd127,  6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd63, 6'd63, 1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd31, 6'd32, 1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_SPRITE_SIZE,  10'd65,   6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd32, 6'd63, 1'b0, 8'd0,   8'd0},
        // zero size: everything outside
        '{1'b1, CFG_SPRITE_SIZE,  10'd0,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd0,  6'd0,  1'b1, 8'd0,   8'd0},
        // single pixel sprite
        '{1'b1, CFG_SPRITE_SIZE,  10'd1,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd1,  6'd0,  1'b1, 8'd0,   8'd0},
        // high data bits above the register width are dropped: size 64
        '{1'b1, CFG_SPRITE_SIZE,  10'h3C0,  6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_ARM_LENGTH,   10'd1023, 6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_OUTLINE_HALF, 10'd1023, 6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_CORE_HALF,    10'd1023, 6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd0,  6'd63, 1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd63, 6'd0,  1'b0, 8'd0,   8'd0},
        // zero thresholds: odd distances never reach zero
        '{1'b1, CFG_ARM_LENGTH,   10'd0,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_OUTLINE_HALF, 10'd0,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_CORE_HALF,    10'd0,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd31, 6'd31, 1'b1, 8'd0,   8'd0},
        // core wider than outline; premultiply off through bit 0 only
        '{1'b1, CFG_ARM_LENGTH,   10'd300,  6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_OUTLINE_HALF, 10'd5,    6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_CORE_HALF,    10'd200,  6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b1, CFG_PREMULTIPLY,  10'h3FE,  6'd0,  6'd0,  1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd31, 6'd40, 1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd40, 6'd32, 1'b0, 8'd0,   8'd0},
        '{1'b0, CFG_SPRITE_SIZE,  10'd0,    6'd33, 6'd31, 1'b0, 8'd0,   8'd0}
    };

    // Expected shade of one pixel under the shadow registers
    function automatic t_out_item crosshair_shade(logic [COORD_W-1:0] col,
                                                  logic [COORD_W-1:0] row);
        int        side;
        int        ctr4;
        int        dx;
        int        dy;
        int        covered;
        int        core;
        int        grey;
        logic      v_arm;
        logic      h_arm;
        t_out_item res;
        res  = '0;
        side = (int'(shade_cfg.sprite_size) > MAX_SIZE) ? MAX_SIZE
                                                       : int'(shade_cfg.sprite_size);
        if (int'(col) >= side || int'(row) >= side)
            return res;
        ctr4    = 4 * (side - 1);
        covered = 0;
        core    = 0;
        for (int sy = 0; sy < SUBS; sy++) begin
            for (int sx = 0; sx < SUBS; sx++) begin
                dx = 8 * int'(col) + 2 * sx + 1 - ctr4;
                dy = 8 * int'(row) + 2 * sy + 1 - ctr4;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                v_arm = dx <= int'(shade_cfg.outline_half_eighths) &&
                        dy <= int'(shade_cfg.arm_length_eighths);
                h_arm = dy <= int'(shade_cfg.outline_half_eighths) &&
                        dx <= int'(shade_cfg.arm_length_eighths);
                if (v_arm || h_arm) begin
                    covered++;
                    if ((v_arm && dx <= int'(shade_cfg.core_half_eighths)) ||
                        (h_arm && dy <= int'(shade_cfg.core_half_eighths)))
                        core++;
                end
            end
        end
        if (covered != 0) begin
            res.alpha = 8'(covered * 255 / 16);
            grey      = core * GREY_FULL / covered;
            if (shade_cfg.premultiply_on)
                grey = grey * int'(res.alpha) / 255;
            res.grey  = 8'(grey);
        end
        return res;
    endfunction

    // Monitor: register writes, accepted pixels, returned shades
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shade_cfg.sprite_size          = RST_SPRITE_SIZE;
            shade_cfg.premultiply_on       = RST_PREMULTIPLY;
            shade_cfg.arm_length_eighths   = RST_ARM_LENGTH;
            shade_cfg.outline_half_eighths = RST_OUTLINE_HALF;
            shade_cfg.core_half_eighths    = RST_CORE_HALF;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPRITE_SIZE:  shade_cfg.sprite_size = i_cfg_data[SIZE_W-1:0];
                    CFG_PREMULTIPLY:  shade_cfg.premultiply_on = i_cfg_data[0];
                    CFG_ARM_LENGTH:   shade_cfg.arm_length_eighths = i_cfg_data;
                    CFG_OUTLINE_HALF: shade_cfg.outline_half_eighths = i_cfg_data;
                    CFG_CORE_HALF:    shade_cfg.core_half_eighths = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                pending_pixels.push_back(typed_on ? typed_shade
                                                  : crosshair_shade(i_in_item.column,
                                                                    i_in_item.row));
            if (o_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("shade item with no pixel pending");
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_out_item.alpha !== want.alpha) begin
                        $error("alpha: expected %0d, got %0d", want.alpha, o_out_item.alpha);
                        fail_count++;
                    end
                    if (o_out_item.grey !== want.grey) begin
                        $error("grey: expected %0d, got %0d", want.grey, o_out_item.grey);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result side: random stalls except during the no-idle stretch
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("antialiased_crosshair_pixel_top verification failed");
                $finish;
            end
        end
    end

    // Offer one pixel and hold it until accepted
    task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic typed, t_out_item shade);
        i_in_valid       <= 1'b1;
        i_in_item.column <= col;
        i_in_item.row    <= row;
        typed_on         <= typed;
        typed_shade      <= shade;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Random sender gaps
    task automatic pixel_gap();
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every pending shade
    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_pixels.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Coordinate near the sprite center line, inside the sprite, or anywhere
    function automatic logic [COORD_W-1:0] pick_coord(int side, int how);
        int c;
        if (side == 0 || how == 2)
            return COORD_W'($urandom_range(0, 63));
        if (how == 0) begin
            c = (side - 1) / 2 + $urandom_range(0, 6) - 3;
            if (c < 0) c = 0;
            if (c > 63) c = 63;
            return COORD_W'(c);
        end
        return COORD_W'($urandom_range(0, side - 1));
    endfunction

    // Stimulus
    initial begin
        int        side;
        int        size;
        int        outline;
        int        how;
        t_out_item shade;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SPRITE_SIZE;
        i_cfg_data  = '0;
        typed_on    = 1'b0;
        typed_shade = '0;
        no_idle     = 1'b0;
        fail_count  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int i = 0; i < N_STEPS; i++) begin
            if (directed_steps[i].is_write) begin
                drain_pixels();
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            end else begin
                pixel_gap();
                shade.alpha = directed_steps[i].alpha;
                shade.grey  = directed_steps[i].grey;
                send_pixel(directed_steps[i].col, directed_steps[i].row,
                           directed_steps[i].typed, shade);
            end
        end

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pixels();
            how = $urandom_range(0, 9);
            size = (how == 0) ? $urandom_range(65, 127) :
                   (how == 1) ? 0 : $urandom_range(1, MAX_SIZE);
            side = (size > MAX_SIZE) ? MAX_SIZE : size;
            write_reg(CFG_SPRITE_SIZE, {3'($urandom_range(0, 7)), 7'(size)});
            write_reg(CFG_PREMULTIPLY, 10'($urandom_range(0, 1023)));
            write_reg(CFG_ARM_LENGTH, ($urandom_range(0, 7) == 0) ? 10'd1023 :
                                      10'($urandom_range(0, 8 * side + 8)));
            outline = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 40);
            write_reg(CFG_OUTLINE_HALF, 10'(outline));
            write_reg(CFG_CORE_HALF, ($urandom_range(0, 9) == 0) ?
                                     10'($urandom_range(0, 1023)) :
                                     10'($urandom_range(0, (outline > 1000) ? 1023
                                                                           : outline + 16)));
            no_idle <= (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off once mid-phase until the pipeline is empty
                if (ph == 6 && n == PHASE_ITEMS / 2)
                    drain_pixels();
                pixel_gap();
                how = $urandom_range(0, 19);
                if (how < 10) begin
                    // one coordinate on a center line
                    if (how[0])
                        send_pixel(pick_coord(side, 0), pick_coord(side, 1), 1'b0, '0);
                    else
                        send_pixel(pick_coord(side, 1), pick_coord(side, 0), 1'b0, '0);
                end else if (how < 16) begin
                    send_pixel(pick_coord(side, 1), pick_coord(side, 1), 1'b0, '0);
                end else begin
                    send_pixel(pick_coord(side, 2), pick_coord(side, 2), 1'b0, '0);
                end
            end
        end

        // Finish: drain, let any stray item show up, then report
        drain_pixels();
        no_idle <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d shade items never returned", pending_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("antialiased_crosshair_pixel_top verification clean");
        else
            $display("antialiased_crosshair_pixel_top verification failed");
        $finish;
    end

endmodule

### files.f
rtl/aacp_pkg.sv
rtl/aacp_dist.sv
rtl/aacp_cover.sv
rtl/aacp_shade.sv
rtl/antialiased_crosshair_pixel_top.sv
tb/sv/tb.sv
